[hdl/prar_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prar_pkg
// Shared widths, constants, tables and word types for the point rotate about
// anchor block.
// ----------------------------------------------------------------------------
package prar_pkg;

  // coordinate and step count
  localparam int COORD_BITS   = 24;
  localparam int CORDIC_STEPS = 16;

  // angle register format, signed Q3.14
  localparam int ANGLE_BITS = 17;

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = (COORD_BITS > ANGLE_BITS) ? COORD_BITS : ANGLE_BITS;

  // offset, gain and datapath widths
  localparam int OFS_W     = COORD_BITS + 1;
  localparam int GAIN_W    = 29;
  localparam int PROD_W    = OFS_W + GAIN_W;
  localparam int FRAC_BITS = 28;
  localparam int XW        = COORD_BITS + 32;
  localparam int ZW        = ANGLE_BITS + 16;
  localparam int RND_BIT   = 15;
  localparam int IW        = XW - FRAC_BITS + 1;
  localparam int SW        = IW + 1;

  // cordic gain correction in Q28
  localparam logic signed [GAIN_W-1:0] GAIN_Q28 = 29'sd163008218;

  // angle limits
  localparam logic signed [ANGLE_BITS-1:0] ANGLE_LIMIT = 17'sd51472;
  localparam logic signed [ZW-1:0]         HALF_PI_Q30 = 33'sd1686629713;
  localparam int QUAD_MIN_INT = 1686629713 / 65536 + 1;
  localparam logic signed [ANGLE_BITS-1:0] QUAD_MIN = ANGLE_BITS'(QUAD_MIN_INT);

  // arctangent table, atan(2^-i) in Q30
  localparam int TABLE_LEN = 24;
  localparam logic signed [ZW-1:0] ATAN_Q30 [TABLE_LEN] = '{
    33'sd843314856, 33'sd497837829, 33'sd263043836, 33'sd133525158,
    33'sd67021686,  33'sd33543515,  33'sd16775850,  33'sd8388437,
    33'sd4194282,   33'sd2097149,   33'sd1048575,   33'sd524287,
    33'sd262143,    33'sd131071,    33'sd65535,     33'sd32767,
    33'sd16383,     33'sd8191,      33'sd4095,      33'sd2047,
    33'sd1023,      33'sd511,       33'sd255,       33'sd127
  };

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_X = 3'd0,
    REG_SRC_Y = 3'd1,
    REG_DST_X = 3'd2,
    REG_DST_Y = 3'd3,
    REG_ANGLE = 3'd4
  } cfg_reg_e;

  // input word
  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
  } point_t;

  // result word
  typedef struct packed {
    logic signed [COORD_BITS-1:0] mapped_x;
    logic signed [COORD_BITS-1:0] mapped_y;
    logic                         saturated;
  } result_t;

endpackage
`default_nettype wire

[hdl/prar_cordic.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prar_cordic
// Pipelined cordic rotation, one registered micro-rotation per stage.
// ----------------------------------------------------------------------------
module prar_cordic (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_vld_i,
  input  wire logic signed [prar_pkg::XW-1:0] in_x_i,
  input  wire logic signed [prar_pkg::XW-1:0] in_y_i,
  input  wire logic signed [prar_pkg::ZW-1:0] in_z_i,
  output logic                                out_vld_o,
  output logic signed [prar_pkg::XW-1:0]      out_x_o,
  output logic signed [prar_pkg::XW-1:0]      out_y_o
);
  import prar_pkg::*;

  // stage registers
  logic [CORDIC_STEPS-1:0] vld_q;
  logic signed [XW-1:0]    x_q [CORDIC_STEPS];
  logic signed [XW-1:0]    y_q [CORDIC_STEPS];
  logic signed [ZW-1:0]    z_q [CORDIC_STEPS-1];

  genvar i;
  for (i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    logic                 vin;
    logic signed [XW-1:0] xin;
    logic signed [XW-1:0] yin;
    logic signed [ZW-1:0] zin;
    logic signed [XW-1:0] xsh;
    logic signed [XW-1:0] ysh;
    logic                 rot_pos;

    // stage input select
    if (i == 0) begin : g_first
      assign vin = in_vld_i;
      assign xin = in_x_i;
      assign yin = in_y_i;
      assign zin = in_z_i;
    end else begin : g_next
      assign vin = vld_q[i-1];
      assign xin = x_q[i-1];
      assign yin = y_q[i-1];
      assign zin = z_q[i-1];
    end

    // arithmetic shifts round toward minus infinity
    assign xsh     = xin >>> i;
    assign ysh     = yin >>> i;
    assign rot_pos = !zin[ZW-1];

    // valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vin;
      end
    end

    // micro-rotation
    always_ff @(posedge clk_i) begin
      x_q[i] <= rot_pos ? (xin - ysh) : (xin + ysh);
      y_q[i] <= rot_pos ? (yin + xsh) : (yin - xsh);
    end

    // residual angle, not needed after the last stage
    if (i < CORDIC_STEPS - 1) begin : g_angle
      always_ff @(posedge clk_i) begin
        z_q[i] <= rot_pos ? (zin - ATAN_Q30[i]) : (zin + ATAN_Q30[i]);
      end
    end
  end

  assign out_vld_o = vld_q[CORDIC_STEPS-1];
  assign out_x_o   = x_q[CORDIC_STEPS-1];
  assign out_y_o   = y_q[CORDIC_STEPS-1];

endmodule
`default_nettype wire

[hdl/point_rotate_about_anchor.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// point_rotate_about_anchor
// Rotates a point about a source anchor and moves it onto a destination
// anchor, using a pipelined cordic with gain correction.
// ----------------------------------------------------------------------------
// Usage
//   Input: a point word is taken at a rising edge with start high and busy
//   low. busy is always low, so a new word may enter in every cycle.
//   Output: done_o is high for one cycle while result_o holds the mapped
//   point and the saturation flag. The receiver cannot stall; every result
//   is presented exactly once, in input order.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0/1 source anchor x/y, 2/3 destination anchor x/y, 4 angle) at the
//   clock edge; other indexes are ignored. Write only while nothing is in
//   flight.
//   Pipeline: between the accepting edge and done_o high, a word passes
//   registered stages for offset, gain multiply, one stage per
//   micro-rotation, magnitude, rounding, and anchor add with clip.
//   Throughput: one word per cycle, set by the fully pipelined cordic.
//   Reset: clears all valid bits and all configuration registers; no
//   clearing pass, the block takes words right after reset.
// ----------------------------------------------------------------------------
module point_rotate_about_anchor (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire prar_pkg::point_t                point_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [prar_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [prar_pkg::CFG_W-1:0]      cfg_data_i,
  output logic                                 done_o,
  output prar_pkg::result_t                    result_o
);
  import prar_pkg::*;

  // configuration registers
  logic signed [COORD_BITS-1:0] src_x_q, src_y_q, dst_x_q, dst_y_q;
  logic signed [ANGLE_BITS-1:0] angle_q;

  // angle preprocessing
  logic signed [ANGLE_BITS-1:0] angle_cl;
  logic signed [ZW-1:0]         z_full;
  logic signed [ZW-1:0]         z_init;
  logic                         quad_pos;
  logic                         quad_neg;

  // offset stage
  logic                    s0_vld_q;
  logic signed [OFS_W-1:0] ox_d, oy_d, ox_q, oy_q;
  logic signed [OFS_W-1:0] px, py, sx, sy;

  // gain stage
  logic                     s1_vld_q;
  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic signed [XW-1:0]     x1_q, y1_q;
  logic signed [ZW-1:0]     z1_q;

  // cordic output
  logic                 cr_vld;
  logic signed [XW-1:0] cr_x, cr_y;

  // magnitude stage
  logic          sa_vld_q;
  logic          sa_neg_x_q, sa_neg_y_q;
  logic [XW-1:0] sa_mag_x_q, sa_mag_y_q;

  // rounding stage
  logic                  sb_vld_q;
  logic [XW-1:0]         rnd_x, rnd_y;
  logic signed [IW-1:0]  int_x_d, int_y_d, int_x_q, int_y_q;

  // anchor add and clip stage
  logic signed [SW-1:0] sum_x, sum_y;
  logic signed [SW-1:0] hi_lim, lo_lim;
  logic                 sat_x, sat_y;
  result_t              res_d, res_q;
  logic                 done_q;

  assign busy = 1'b0;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_x_q <= '0;
      src_y_q <= '0;
      dst_x_q <= '0;
      dst_y_q <= '0;
      angle_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SRC_X: src_x_q <= cfg_data_i[COORD_BITS-1:0];
        REG_SRC_Y: src_y_q <= cfg_data_i[COORD_BITS-1:0];
        REG_DST_X: dst_x_q <= cfg_data_i[COORD_BITS-1:0];
        REG_DST_Y: dst_y_q <= cfg_data_i[COORD_BITS-1:0];
        REG_ANGLE: angle_q <= cfg_data_i[ANGLE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // clamp angle, fold beyond a quarter turn
  always_comb begin
    if (angle_q > ANGLE_LIMIT) begin
      angle_cl = ANGLE_LIMIT;
    end else if (angle_q < -ANGLE_LIMIT) begin
      angle_cl = -ANGLE_LIMIT;
    end else begin
      angle_cl = angle_q;
    end
    quad_pos = (angle_cl >= QUAD_MIN);
    quad_neg = (angle_cl <= -QUAD_MIN);
    z_full   = {angle_cl, 16'b0};
    if (quad_pos) begin
      z_init = z_full - HALF_PI_Q30;
    end else if (quad_neg) begin
      z_init = z_full + HALF_PI_Q30;
    end else begin
      z_init = z_full;
    end
  end

  // offsets from source anchor, with the quarter turn applied
  assign px = {point_i.point_x[COORD_BITS-1], point_i.point_x};
  assign py = {point_i.point_y[COORD_BITS-1], point_i.point_y};
  assign sx = {src_x_q[COORD_BITS-1], src_x_q};
  assign sy = {src_y_q[COORD_BITS-1], src_y_q};

  always_comb begin
    if (quad_pos) begin
      ox_d = sy - py;
      oy_d = px - sx;
    end else if (quad_neg) begin
      ox_d = py - sy;
      oy_d = sx - px;
    end else begin
      ox_d = px - sx;
      oy_d = py - sy;
    end
  end

  // gain correction products
  assign prod_x = ox_q * GAIN_Q28;
  assign prod_y = oy_q * GAIN_Q28;

  // front valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= start && !busy;
      s1_vld_q <= s0_vld_q;
    end
  end

  // front payload
  always_ff @(posedge clk_i) begin
    ox_q <= ox_d;
    oy_q <= oy_d;
    x1_q <= {{(XW-PROD_W){prod_x[PROD_W-1]}}, prod_x};
    y1_q <= {{(XW-PROD_W){prod_y[PROD_W-1]}}, prod_y};
    z1_q <= z_init;
  end

  prar_cordic u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (s1_vld_q),
    .in_x_i    (x1_q),
    .in_y_i    (y1_q),
    .in_z_i    (z1_q),
    .out_vld_o (cr_vld),
    .out_x_o   (cr_x),
    .out_y_o   (cr_y)
  );

  // round half away from zero at Q12, then truncate toward zero
  assign rnd_x = sa_mag_x_q + XW'(1 << RND_BIT);
  assign rnd_y = sa_mag_y_q + XW'(1 << RND_BIT);

  always_comb begin
    int_x_d = $signed({1'b0, rnd_x[XW-1:FRAC_BITS]});
    int_y_d = $signed({1'b0, rnd_y[XW-1:FRAC_BITS]});
    if (sa_neg_x_q) begin
      int_x_d = -int_x_d;
    end
    if (sa_neg_y_q) begin
      int_y_d = -int_y_d;
    end
  end

  // destination anchor add and clip
  assign hi_lim = {{(SW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  assign lo_lim = ~hi_lim;
  assign sum_x  = {int_x_q[IW-1], int_x_q}
                + {{(SW-COORD_BITS){dst_x_q[COORD_BITS-1]}}, dst_x_q};
  assign sum_y  = {int_y_q[IW-1], int_y_q}
                + {{(SW-COORD_BITS){dst_y_q[COORD_BITS-1]}}, dst_y_q};

  always_comb begin
    sat_x = (sum_x > hi_lim) || (sum_x < lo_lim);
    sat_y = (sum_y > hi_lim) || (sum_y < lo_lim);
    if (sum_x > hi_lim) begin
      res_d.mapped_x = hi_lim[COORD_BITS-1:0];
    end else if (sum_x < lo_lim) begin
      res_d.mapped_x = lo_lim[COORD_BITS-1:0];
    end else begin
      res_d.mapped_x = sum_x[COORD_BITS-1:0];
    end
    if (sum_y > hi_lim) begin
      res_d.mapped_y = hi_lim[COORD_BITS-1:0];
    end else if (sum_y < lo_lim) begin
      res_d.mapped_y = lo_lim[COORD_BITS-1:0];
    end else begin
      res_d.mapped_y = sum_y[COORD_BITS-1:0];
    end
    res_d.saturated = sat_x || sat_y;
  end

  // back valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_vld_q <= 1'b0;
      sb_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      sa_vld_q <= cr_vld;
      sb_vld_q <= sa_vld_q;
      done_q   <= sb_vld_q;
    end
  end

  // back payload
  always_ff @(posedge clk_i) begin
    sa_neg_x_q <= cr_x[XW-1];
    sa_neg_y_q <= cr_y[XW-1];
    sa_mag_x_q <= cr_x[XW-1] ? XW'(-cr_x) : XW'(cr_x);
    sa_mag_y_q <= cr_y[XW-1] ? XW'(-cr_y) : XW'(cr_y);
    int_x_q    <= int_x_d;
    int_y_q    <= int_y_d;
    res_q      <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
`default_nettype wire
